/* rtl/core/ppt_pkg.sv */
package ppt_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;

   localparam int PROD_W = 2 * COORD_WIDTH;        // exact product
   localparam int SUM_W  = PROD_W + 2;             // exact three-term sum
   localparam int MAG_W  = PROD_W;                 // magnitude of a sum
   localparam int DEN_W  = MAG_W + 1 - FRAC_BITS;  // rounded w magnitude
   localparam int CSR_W  = 2 * COORD_WIDTH;
   localparam int IDX_W  = 3;
   localparam int LATENCY = MAG_W + 4;

   localparam logic [IDX_W-1:0] CSR_MODE    = 3'd0;
   localparam logic [IDX_W-1:0] CSR_COEF_A  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_COEF_B  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_COEF_C  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_COEF_D  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_COEF_EF = 3'd5;
   localparam logic [IDX_W-1:0] CSR_COEF_GH = 3'd6;
   localparam logic [IDX_W-1:0] CSR_COEF_I  = 3'd7;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] y_in;
      logic signed [COORD_WIDTH-1:0] x_in;
   } req_type;

   typedef struct packed {
      logic                          saturated;
      logic signed [COORD_WIDTH-1:0] y_out;
      logic signed [COORD_WIDTH-1:0] x_out;
   } rsp_type;

   typedef struct packed {
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] a;
      logic signed [COORD_WIDTH-1:0] b;
      logic signed [COORD_WIDTH-1:0] c;
      logic signed [COORD_WIDTH-1:0] d;
      logic signed [COORD_WIDTH-1:0] e;
      logic signed [COORD_WIDTH-1:0] f;
      logic signed [COORD_WIDTH-1:0] g;
      logic signed [COORD_WIDTH-1:0] h;
      logic signed [COORD_WIDTH-1:0] i;
   } cfg_type;

   // data handed from cell to cell; num holds dividend bits, then quotient bits
   typedef struct packed {
      logic             valid;
      logic             neg_x;
      logic             neg_y;
      logic [MAG_W-1:0] num_x;
      logic [MAG_W-1:0] num_y;
      logic [DEN_W-1:0] rem_x;
      logic [DEN_W-1:0] rem_y;
      logic [DEN_W-1:0] den;
   } cell_type;

endpackage

/* rtl/core/projective_point_transform_top.sv */
// Pipeline: 3 front stages, one divider cell per quotient bit, one output stage.
// Throughput: one transaction per cycle; busy is never raised.
// The divider is a chain of 64 cells, one quotient bit each, for both coordinates.
// Synchronous active-high reset clears valids and loads the identity matrix, linear mode.
// The receiver cannot stall; each result is shown for exactly one cycle.
module projective_point_transform_top import ppt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int CW = COORD_WIDTH;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 1'b0, a: CW'(1 << FRAC_BITS), b: '0, c: '0,
                     d: CW'(1 << FRAC_BITS), e: '0, f: '0, g: '0, h: '0,
                     i: CW'(1 << FRAC_BITS)};
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:    cfg_ff.mode <= csr_wdata[0];
            CSR_COEF_A:  cfg_ff.a <= csr_wdata[CW-1:0];
            CSR_COEF_B:  cfg_ff.b <= csr_wdata[CW-1:0];
            CSR_COEF_C:  cfg_ff.c <= csr_wdata[CW-1:0];
            CSR_COEF_D:  cfg_ff.d <= csr_wdata[CW-1:0];
            CSR_COEF_EF: begin
               cfg_ff.e <= csr_wdata[CW-1:0];
               cfg_ff.f <= csr_wdata[2*CW-1:CW];
            end
            CSR_COEF_GH: begin
               cfg_ff.g <= csr_wdata[CW-1:0];
               cfg_ff.h <= csr_wdata[2*CW-1:CW];
            end
            CSR_COEF_I:  cfg_ff.i <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   cell_type chain [0:MAG_W];

   ppt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .req      (req_data),
      .cfg      (cfg_ff),
      .cell_out (chain[0])
   );

   for (genvar k = 0; k < MAG_W; k++) begin : g_cell
      ppt_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   ppt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cell_in   (chain[MAG_W]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/ppt_front.sv */
module ppt_front import ppt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   input  cfg_type  cfg,
   output cell_type cell_out
);

   localparam int CW = COORD_WIDTH;

   // stage 1: products
   logic                     v1_ff, m1_ff;
   logic signed [PROD_W-1:0] pax_ff, pcy_ff, pbx_ff, pdy_ff, pgx_ff, phy_ff;

   // stage 2: exact sums
   logic                     v2_ff, m2_ff;
   logic signed [SUM_W-1:0]  sx_ff, sy_ff, sw_ff;
   logic signed [SUM_W-1:0]  sx_in, sy_in, sw_in;

   // stage 3: magnitudes and rounding
   cell_type                 c3_ff, c3_in;

   always_ff @(posedge clock) begin
      pax_ff <= cfg.a * req.x_in;
      pcy_ff <= cfg.c * req.y_in;
      pbx_ff <= cfg.b * req.x_in;
      pdy_ff <= cfg.d * req.y_in;
      pgx_ff <= cfg.g * req.x_in;
      phy_ff <= cfg.h * req.y_in;
      m1_ff  <= cfg.mode;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      sw_ff  <= sw_in;
      m2_ff  <= m1_ff;
      c3_ff  <= c3_in;
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   function automatic logic signed [SUM_W-1:0] offset(input logic signed [CW-1:0] v, input logic en);
      logic signed [SUM_W-1:0] t;
      t = {{(SUM_W-CW-FRAC_BITS){v[CW-1]}}, v, {FRAC_BITS{1'b0}}};
      return en ? t : '0;
   endfunction

   always_comb begin
      sx_in = SUM_W'(pax_ff) + SUM_W'(pcy_ff) + offset(cfg.e, m1_ff);
      sy_in = SUM_W'(pbx_ff) + SUM_W'(pdy_ff) + offset(cfg.f, m1_ff);
      sw_in = SUM_W'(pgx_ff) + SUM_W'(phy_ff) + offset(cfg.i, 1'b1);
   end

   logic             nx_neg, ny_neg, w_neg;
   logic [MAG_W-1:0] mx, my, mw;
   logic [MAG_W:0]   rx, ry, rw;
   logic [DEN_W-1:0] dx, dy, dw;

   always_comb begin
      nx_neg = sx_ff[SUM_W-1];
      ny_neg = sy_ff[SUM_W-1];
      w_neg  = sw_ff[SUM_W-1];
      mx = nx_neg ? MAG_W'(-sx_ff) : MAG_W'(sx_ff);
      my = ny_neg ? MAG_W'(-sy_ff) : MAG_W'(sy_ff);
      mw = w_neg  ? MAG_W'(-sw_ff) : MAG_W'(sw_ff);
      rx = {1'b0, mx} + (MAG_W+1)'(1 << (FRAC_BITS-1));
      ry = {1'b0, my} + (MAG_W+1)'(1 << (FRAC_BITS-1));
      rw = {1'b0, mw} + (MAG_W+1)'(1 << (FRAC_BITS-1));
      dx = rx[MAG_W:FRAC_BITS];
      dy = ry[MAG_W:FRAC_BITS];
      dw = rw[MAG_W:FRAC_BITS];

      c3_in.valid = v2_ff & ~reset;
      c3_in.rem_x = '0;
      c3_in.rem_y = '0;
      if (m2_ff) begin
         c3_in.num_x = mx;
         c3_in.num_y = my;
         if (dw == '0) begin
            // zero w is replaced by +1 LSB
            c3_in.den   = DEN_W'(1);
            c3_in.neg_x = nx_neg;
            c3_in.neg_y = ny_neg;
         end else begin
            c3_in.den   = dw;
            c3_in.neg_x = nx_neg ^ w_neg;
            c3_in.neg_y = ny_neg ^ w_neg;
         end
      end else begin
         // linear: divide the rounded sums by one
         c3_in.num_x = MAG_W'(dx);
         c3_in.num_y = MAG_W'(dy);
         c3_in.den   = DEN_W'(1);
         c3_in.neg_x = nx_neg;
         c3_in.neg_y = ny_neg;
      end
   end

   assign cell_out = c3_ff;

endmodule

/* rtl/core/ppt_div_cell.sv */
module ppt_div_cell import ppt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_in,
   output cell_type cell_out
);

   cell_type cell_ff, cell_in_q;
   logic [DEN_W:0] tx, ty;
   logic           qx, qy;

   // one restoring step for each coordinate
   always_comb begin
      cell_in_q = cell_in;
      cell_in_q.valid = cell_in.valid & ~reset;
      tx = {cell_in.rem_x, cell_in.num_x[MAG_W-1]};
      ty = {cell_in.rem_y, cell_in.num_y[MAG_W-1]};
      qx = tx >= {1'b0, cell_in.den};
      qy = ty >= {1'b0, cell_in.den};
      cell_in_q.rem_x = qx ? DEN_W'(tx - {1'b0, cell_in.den}) : DEN_W'(tx);
      cell_in_q.rem_y = qy ? DEN_W'(ty - {1'b0, cell_in.den}) : DEN_W'(ty);
      cell_in_q.num_x = {cell_in.num_x[MAG_W-2:0], qx};
      cell_in_q.num_y = {cell_in.num_y[MAG_W-2:0], qy};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_q;
   end

   assign cell_out = cell_ff;

endmodule

/* rtl/core/ppt_back.sv */
module ppt_back import ppt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_in,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int CW = COORD_WIDTH;

   logic    valid_ff;
   rsp_type data_ff, data_in;

   function automatic logic [CW:0] clip(input logic neg, input logic [MAG_W:0] mag);
      logic [MAG_W:0] lim;
      logic [MAG_W:0] m;
      logic           sat;
      lim = (MAG_W+1)'(1) << (CW-1);
      m   = mag;
      sat = 1'b0;
      if (!neg && mag > lim - 1'b1) begin
         m = lim - 1'b1;
         sat = 1'b1;
      end
      if (neg && mag > lim) begin
         m = lim;
         sat = 1'b1;
      end
      m = neg ? -m : m;
      return {sat, m[CW-1:0]};
   endfunction

   logic [DEN_W:0] r2x, r2y;
   logic [MAG_W:0] qx, qy;
   logic [CW:0]    ox, oy;

   always_comb begin
      // round half away from zero: bump when 2r >= w
      r2x = {cell_in.rem_x, 1'b0};
      r2y = {cell_in.rem_y, 1'b0};
      qx = {1'b0, cell_in.num_x} + (MAG_W+1)'(r2x >= {1'b0, cell_in.den});
      qy = {1'b0, cell_in.num_y} + (MAG_W+1)'(r2y >= {1'b0, cell_in.den});
      ox = clip(cell_in.neg_x && qx != '0, qx);
      oy = clip(cell_in.neg_y && qy != '0, qy);
      data_in.x_out     = ox[CW-1:0];
      data_in.y_out     = oy[CW-1:0];
      data_in.saturated = ox[CW] | oy[CW];
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/core/ppt_checker.sv */
module ppt_checker import ppt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   localparam logic [COORD_WIDTH-1:0] MAX_V = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] MIN_V = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching transaction");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("transaction lost");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.x_out == MAX_V || rsp_data.x_out == MIN_V ||
          rsp_data.y_out == MAX_V || rsp_data.y_out == MIN_V))
      else $error("saturated flag without clipped output");

endmodule

bind projective_point_transform_top ppt_checker u_ppt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
